[sv/assert_macros.svh]
// Assertion helpers for the stack calculator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[sv/isc_pkg.sv]
package isc_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int DATA_W      = 32;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int DEPTH_NOW_W = 7;
   localparam int MODE_W      = 3;
   localparam int STATUS_W    = 2;
   localparam int STEP_W      = $clog2(DATA_W);

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH = 3'd0,
      MODE_POP  = 3'd1,
      MODE_TOP  = 3'd2,
      MODE_ADD  = 3'd3,
      MODE_SUB  = 3'd4,
      MODE_MUL  = 3'd5,
      MODE_DIV  = 3'd6
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2,
      ST_DIVZ  = 2'd3
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic div_start;
      logic commit;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic needs_div;
      logic div_done;
   } dp_status_type;

endpackage

[sv/isc_div.sv]
module isc_div
   import isc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic              done,
   output logic [DATA_W-1:0] quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DATA_W:0]   rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic              neg_ff, neg_in;

   logic [DATA_W:0]   rem_shift;
   logic [DATA_W:0]   rem_sub;
   logic              fits;

   // restoring division on magnitudes, one quotient bit per cycle
   always_comb begin
      rem_shift = {rem_ff[DATA_W-1:0], quo_ff[DATA_W-1]};
      rem_sub   = rem_shift - {1'b0, dvs_ff};
      fits      = (rem_shift >= {1'b0, dvs_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;

      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
         dvs_in  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      end else if (busy_ff) begin
         rem_in  = fits ? rem_sub : rem_shift;
         quo_in  = {quo_ff[DATA_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

[sv/isc_dp.sv]
module isc_dp
   import isc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             cmd,
   output dp_status_type          sts,
   input  logic [MODE_W-1:0]      req_mode,
   input  logic [DATA_W-1:0]      req_value,
   output logic [DATA_W-1:0]      out_result,
   output logic [STATUS_W-1:0]    out_status,
   output logic [DEPTH_NOW_W-1:0] out_depth
);

   logic [DATA_W-1:0] stack_mem [STACK_DEPTH];

   mode_type             mode_ff, mode_in;
   logic [DATA_W-1:0]    value_ff, value_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [DATA_W-1:0]    rd0_ff, rd1_ff;
   logic                 quo_ready_ff, quo_ready_in;
   logic [DATA_W-1:0]    result_ff, result_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [DEPTH_NOW_W-1:0] depth_ff, depth_in;

   logic [ADDR_W-1:0]    rd0_addr, rd1_addr;
   logic                 has_one, has_two, full, under;
   logic [DATA_W-1:0]    opa, opb, product, quotient;
   logic [COUNT_W-1:0]   base, new_count;
   logic [DATA_W-1:0]    res;
   status_type           st;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [DATA_W-1:0]    wr_data;
   logic                 div_done;

   isc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (opa),
      .divisor  (opb),
      .done     (div_done),
      .quotient (quotient)
   );

   assign rd0_addr = ADDR_W'(count_ff - COUNT_W'(1));
   assign rd1_addr = ADDR_W'(count_ff - COUNT_W'(2));

   // operands, with -1 standing in for a missing entry
   always_comb begin
      has_one = (count_ff != '0);
      has_two = (count_ff > COUNT_W'(1));
      full    = (count_ff == COUNT_W'(STACK_DEPTH));
      opa     = has_one ? rd0_ff : '1;
      opb     = has_two ? rd1_ff : '1;
      base    = has_two ? (count_ff - COUNT_W'(2)) : '0;
      product = opa * opb;
   end

   always_comb begin
      res       = '0;
      st        = ST_OK;
      under     = 1'b0;
      new_count = count_ff;
      wr_en     = 1'b0;
      wr_addr   = base[ADDR_W-1:0];
      wr_data   = '0;
      unique case (mode_ff)
         MODE_PUSH: begin
            if (full) begin
               st = ST_OVER;
            end else begin
               wr_en     = 1'b1;
               wr_addr   = count_ff[ADDR_W-1:0];
               wr_data   = value_ff;
               new_count = count_ff + COUNT_W'(1);
            end
         end
         MODE_POP: begin
            res   = opa;
            under = !has_one;
            if (has_one) begin
               new_count = count_ff - COUNT_W'(1);
            end
         end
         MODE_TOP: begin
            res   = opa;
            under = !has_one;
         end
         MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
            under = !has_two;
            unique case (mode_ff)
               MODE_ADD: res = opa + opb;
               MODE_SUB: res = opa - opb;
               MODE_MUL: res = product;
               default: begin
                  if (opb == '0) begin
                     res = '0;
                     st  = ST_DIVZ;
                  end else begin
                     res = quotient;
                  end
               end
            endcase
            wr_en     = 1'b1;
            wr_data   = res;
            new_count = base + COUNT_W'(1);
         end
         default: ;
      endcase
      if (under && st == ST_OK) begin
         st = ST_UNDER;
      end
   end

   assign sts.needs_div = (mode_ff == MODE_DIV) && (opb != '0) && !quo_ready_ff;
   assign sts.div_done  = div_done;

   always_comb begin
      mode_in      = mode_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      quo_ready_in = quo_ready_ff;
      result_in    = result_ff;
      status_in    = status_ff;
      depth_in     = depth_ff;
      if (cmd.capture) begin
         mode_in      = mode_type'(req_mode);
         value_in     = req_value;
         quo_ready_in = 1'b0;
      end else if (div_done) begin
         quo_ready_in = 1'b1;
      end
      if (cmd.commit) begin
         count_in  = new_count;
         result_in = res;
         status_in = st;
         depth_in  = DEPTH_NOW_W'(new_count);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         quo_ready_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         quo_ready_ff <= quo_ready_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      value_ff  <= value_in;
      result_ff <= result_in;
      status_ff <= status_in;
      depth_ff  <= depth_in;
   end

   // stack memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      if (cmd.capture) begin
         rd0_ff <= stack_mem[rd0_addr];
         rd1_ff <= stack_mem[rd1_addr];
      end
   end

   assign out_result = result_ff;
   assign out_status = status_ff;
   assign out_depth  = depth_ff;

endmodule

[sv/isc_ctrl.sv]
module isc_ctrl
   import isc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output dp_cmd_type    cmd,
   input  dp_status_type sts
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_DIV  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in      = state_ff;
      cmd.capture   = 1'b0;
      cmd.div_start = 1'b0;
      cmd.commit    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (sts.needs_div) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_EXEC;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[sv/integer_stack_calculator_unit.sv]
// Response: rsp_valid is registered from the commit in the execute state, which follows
//   request capture; push, pop, top, add, subtract, multiply and a zero-divisor divide
//   commit directly, while a divide first runs the bit-serial divider.
// Commit waits while a held response is stalled; a new request is taken only once the
//   previous one has committed. Each operation reads, then writes, the stack memory.
// Reset (synchronous, active high) empties the stack and clears the controller and
//   response valid; stack memory contents are left as they are, no clearing pass.
`include "assert_macros.svh"

module integer_stack_calculator_unit
   import isc_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [MODE_W-1:0]             req_mode,
   input  logic signed [DATA_W-1:0]      req_value,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [DATA_W-1:0]      rsp_result,
   output logic [STATUS_W-1:0]           rsp_status,
   output logic [DEPTH_NOW_W-1:0]        rsp_depth_now
);

   // Controller walks each transaction through capture (memory read of the two
   // top entries), execute, and an optional divide phase; the datapath holds
   // the stack, the count, the operand substitution and the response register.
   dp_cmd_type    cmd;
   dp_status_type sts;

   isc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // The response register sits in the datapath, so a finished transaction can
   // wait on rsp_stall while the next request is already being taken in.
   isc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_mode   (req_mode),
      .req_value  (req_value),
      .out_result (rsp_result),
      .out_status (rsp_status),
      .out_depth  (rsp_depth_now)
   );

   // checks
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall, "request taken while busy")
   `ASSERT_IMPLY(a_depth_bound, clock, reset, rsp_valid, rsp_depth_now <= DEPTH_NOW_W'(STACK_DEPTH), "depth beyond stack size")
   `ASSERT_IMPLY(a_divz_zero, clock, reset, rsp_valid && rsp_status == ST_DIVZ, rsp_result == '0, "divide by zero result not zero")
   `ASSERT_IMPLY(a_over_full, clock, reset, rsp_valid && rsp_status == ST_OVER, rsp_depth_now == DEPTH_NOW_W'(STACK_DEPTH), "overflow on a stack not full")

endmodule
